// File: hdl/bff_pkg.sv
package bff_pkg;

  localparam int MAX_BITS    = 65536;
  localparam int MAX_HASHES  = 16;
  localparam int MIN_BITS    = 64;
  localparam int STORE_BYTES = MAX_BITS / 8;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int POS_W       = $clog2(MAX_BITS);
  localparam int BITS_W      = 17;
  localparam int HCNT_W      = 5;
  localparam int HASH_W      = 64;
  localparam int DIGIT_W     = 4;
  localparam int MOD_STEPS   = HASH_W / DIGIT_W;
  localparam int DIG_CNT_W   = $clog2(MOD_STEPS);

  localparam logic [HASH_W-1:0] HASH_SEED = 64'hcbf29ce484222325;
  localparam logic [HASH_W-1:0] FNV_PRIME = 64'd1099511628211;
  localparam logic [HASH_W-1:0] LCG_MUL   = 64'd6364136223846793005;
  localparam logic [HASH_W-1:0] LCG_INC   = 64'd1442695040888963407;

  typedef enum logic [1:0] {
    MODE_ADD   = 2'd0,
    MODE_QUERY = 2'd1,
    MODE_LOAD  = 2'd2,
    MODE_READ  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    CFG_BIT_COUNT  = 2'd0,
    CFG_HASH_COUNT = 2'd1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_MOD,
    ST_RD,
    ST_RMW,
    ST_RDB,
    ST_RES
  } core_state_e;

  typedef struct packed {
    mode_e             mode;
    logic [7:0]        data;
    logic              has;
    logic              last;
    logic [ADDR_W-1:0] idx;
  } item_t;

endpackage

// File: hdl/bloom_filter_fnv_double_hash.sv
// Bloom filter over a 65536-bit store with FNV-1a / LCG double hashing.
// Requests enter a two-deep queue; a back-end sequencer drains it one request at a time.
// A term byte is hashed with two 64-bit products on parallel multipliers, each built from
// three 32x32 partial products over four steps. The last byte of a term adds, per probe,
// a remainder reduction (4 bits a cycle) plus a store read-modify-write.
// After reset the store is cleared one byte a cycle, during which
// requests are stalled; configuration writes are taken at any time.
module bloom_filter_fnv_double_hash (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  data_byte_i,
  input  logic        has_byte_i,
  input  logic        last_i,
  input  logic [12:0] byte_index_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic        present_o,
  output logic [7:0]  read_byte_o,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [16:0] cfg_value_i
);

  logic [bff_pkg::BITS_W-1:0] bit_count_q;
  logic [bff_pkg::HCNT_W-1:0] hash_count_q;
  bff_pkg::item_t             in_item, q_item;
  logic                       q_empty, q_pop, clearing;

  assign cfg_ready_o = 1'b1;

  // register writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_count_q  <= bff_pkg::BITS_W'(bff_pkg::MAX_BITS);
      hash_count_q <= bff_pkg::HCNT_W'(7);
    end else if (cfg_valid_i) begin
      case (bff_pkg::cfg_idx_e'(cfg_index_i))
        bff_pkg::CFG_BIT_COUNT:  bit_count_q  <= cfg_value_i;
        bff_pkg::CFG_HASH_COUNT: hash_count_q <= cfg_value_i[bff_pkg::HCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // pack request fields
  assign in_item.mode = bff_pkg::mode_e'(mode_i);
  assign in_item.data = data_byte_i;
  assign in_item.has  = has_byte_i;
  assign in_item.last = last_i;
  assign in_item.idx  = byte_index_i;

  // front: request queue, held off while the store is cleared
  bff_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(in_valid_i), .hold_i(clearing), .item_i(in_item), .stall_o(in_stall_o),
    .pop_i(q_pop), .empty_o(q_empty), .item_o(q_item)
  );

  // back: hashing, probing and store access
  bff_core u_core (
    .clk_i, .rst_ni,
    .bit_count_i(bit_count_q), .hash_count_i(hash_count_q),
    .q_empty_i(q_empty), .q_item_i(q_item), .q_pop_o(q_pop), .clearing_o(clearing),
    .out_valid_o, .out_stall_i, .kind_o, .present_o, .read_byte_o
  );

endmodule

// File: hdl/bff_ram.sv
module bff_ram #(
  parameter int Width = 8,
  parameter int Depth = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: hdl/bff_queue.sv
module bff_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic          hold_i,
  input  bff_pkg::item_t item_i,
  output logic          stall_o,
  input  logic          pop_i,
  output logic          empty_o,
  output bff_pkg::item_t item_o
);

  bff_pkg::item_t slot_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push;

  assign stall_o = (cnt_q == 2'd2) | hold_i;
  assign empty_o = (cnt_q == 2'd0);
  assign item_o  = slot_q[rd_q];
  assign do_push = push_i & ~stall_o;

  always_comb begin
    wr_d  = wr_q ^ do_push;
    rd_d  = rd_q ^ pop_i;
    cnt_d = cnt_q + {1'b0, do_push} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= item_i;
    end
  end

endmodule

// File: hdl/bff_mul.sv
module bff_mul (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic        done_o,
  output logic [63:0] p_o
);

  logic [63:0] a_q, b_q, prod_q, prod_d, acc_q;
  logic [31:0] op_x, op_y;
  logic [1:0]  step_q;
  logic        busy_q, done_q;

  // low 64 bits only: lo*lo + (lo*hi + hi*lo) << 32
  always_comb begin
    case (step_q)
      2'd0:    begin op_x = a_q[31:0];  op_y = b_q[31:0];  end
      2'd1:    begin op_x = a_q[31:0];  op_y = b_q[63:32]; end
      default: begin op_x = a_q[63:32]; op_y = b_q[31:0];  end
    endcase
    prod_d = {32'd0, op_x} * {32'd0, op_y};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= 2'd0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= 2'd0;
    end else if (busy_q) begin
      step_q <= step_q + 2'd1;
      if (step_q == 2'd3) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
    end else if (busy_q) begin
      prod_q <= prod_d;
      case (step_q)
        2'd0:    acc_q <= acc_q;
        2'd1:    acc_q <= prod_q;
        default: acc_q <= acc_q + {prod_q[31:0], 32'd0};
      endcase
    end
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule

// File: hdl/bff_core.sv
module bff_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [bff_pkg::BITS_W-1:0]   bit_count_i,
  input  logic [bff_pkg::HCNT_W-1:0]   hash_count_i,
  input  logic                         q_empty_i,
  input  bff_pkg::item_t               q_item_i,
  output logic                         q_pop_o,
  output logic                         clearing_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   kind_o,
  output logic                         present_o,
  output logic [7:0]                   read_byte_o
);

  bff_pkg::core_state_e state_q, state_d;

  logic [bff_pkg::BITS_W-1:0]    eff_m;
  logic [bff_pkg::HCNT_W-1:0]    eff_k, n_inc;
  logic [bff_pkg::ADDR_W-1:0]    clr_q;
  bff_pkg::item_t                item_q;
  logic [63:0]                   h1_q, h2_q, sum_q, shift_q, sum_next, cext;
  logic [bff_pkg::BITS_W-1:0]    rem_q, rem_next;
  logic [bff_pkg::DIG_CNT_W-1:0] dig_q;
  logic [bff_pkg::HCNT_W-1:0]    n_q;
  logic                          all_q, res_present_q;
  logic [7:0]                    res_byte_q;
  logic                          out_valid_q, out_present_q;
  logic [1:0]                    out_kind_q;
  logic [7:0]                    out_byte_q;
  logic                          load_out, mul_start, mul1_done, mul2_done;
  logic [63:0]                   p1, p2;
  logic                          mem_we;
  logic [bff_pkg::ADDR_W-1:0]    mem_waddr, mem_raddr;
  logic [7:0]                    mem_wdata, mem_rdata, bit_mask;

  // clamp register values
  always_comb begin
    if (bit_count_i < bff_pkg::BITS_W'(bff_pkg::MIN_BITS)) begin
      eff_m = bff_pkg::BITS_W'(bff_pkg::MIN_BITS);
    end else if (bit_count_i > bff_pkg::BITS_W'(bff_pkg::MAX_BITS)) begin
      eff_m = bff_pkg::BITS_W'(bff_pkg::MAX_BITS);
    end else begin
      eff_m = bit_count_i;
    end
    if (hash_count_i == '0) begin
      eff_k = bff_pkg::HCNT_W'(1);
    end else if (hash_count_i > bff_pkg::HCNT_W'(bff_pkg::MAX_HASHES)) begin
      eff_k = bff_pkg::HCNT_W'(bff_pkg::MAX_HASHES);
    end else begin
      eff_k = hash_count_i;
    end
  end

  assign cext     = {{56{q_item_i.data[7]}}, q_item_i.data};
  assign n_inc    = n_q + bff_pkg::HCNT_W'(1);
  assign sum_next = sum_q + h2_q;
  assign bit_mask = 8'd1 << rem_q[2:0];

  // four remainder digits per cycle, each one compare and subtract
  always_comb begin
    logic [bff_pkg::BITS_W:0]   t;
    logic [bff_pkg::BITS_W-1:0] r;
    r = rem_q;
    for (int i = 0; i < bff_pkg::DIGIT_W; i++) begin
      t = {r, shift_q[63-i]};
      if (t >= {1'b0, eff_m}) begin
        t = t - {1'b0, eff_m};
      end
      r = t[bff_pkg::BITS_W-1:0];
    end
    rem_next = r;
  end

  bff_mul u_mul1 (
    .clk_i, .rst_ni, .start_i(mul_start),
    .a_i(h1_q ^ cext), .b_i(bff_pkg::FNV_PRIME), .done_o(mul1_done), .p_o(p1)
  );

  bff_mul u_mul2 (
    .clk_i, .rst_ni, .start_i(mul_start),
    .a_i(h2_q ^ cext), .b_i(bff_pkg::LCG_MUL), .done_o(mul2_done), .p_o(p2)
  );

  bff_ram #(.Width(8), .Depth(bff_pkg::STORE_BYTES)) u_store (
    .clk_i, .we_i(mem_we), .waddr_i(mem_waddr), .wdata_i(mem_wdata),
    .raddr_i(mem_raddr), .rdata_o(mem_rdata)
  );

  always_comb begin
    state_d   = state_q;
    q_pop_o   = 1'b0;
    mul_start = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = item_q.idx;
    mem_wdata = mem_rdata | bit_mask;
    mem_raddr = rem_q[bff_pkg::POS_W-1:3];
    load_out  = 1'b0;
    unique case (state_q)
      bff_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = 8'd0;
        if (clr_q == bff_pkg::ADDR_W'(bff_pkg::STORE_BYTES - 1)) begin
          state_d = bff_pkg::ST_IDLE;
        end
      end
      bff_pkg::ST_IDLE: begin
        mem_raddr = q_item_i.idx;
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          unique case (q_item_i.mode)
            bff_pkg::MODE_LOAD: begin
              mem_we    = 1'b1;
              mem_waddr = q_item_i.idx;
              mem_wdata = q_item_i.data;
              state_d   = bff_pkg::ST_RES;
            end
            bff_pkg::MODE_READ: state_d = bff_pkg::ST_RDB;
            default: begin
              if (q_item_i.has) begin
                mul_start = 1'b1;
                state_d   = bff_pkg::ST_MUL;
              end else if (q_item_i.last) begin
                state_d = bff_pkg::ST_MOD;
              end
            end
          endcase
        end
      end
      bff_pkg::ST_MUL: begin
        if (mul1_done && mul2_done) begin
          state_d = item_q.last ? bff_pkg::ST_MOD : bff_pkg::ST_IDLE;
        end
      end
      bff_pkg::ST_MOD: begin
        if (dig_q == bff_pkg::DIG_CNT_W'(bff_pkg::MOD_STEPS - 1)) begin
          state_d = bff_pkg::ST_RD;
        end
      end
      bff_pkg::ST_RD: state_d = bff_pkg::ST_RMW;
      bff_pkg::ST_RMW: begin
        mem_waddr = rem_q[bff_pkg::POS_W-1:3];
        mem_we    = (item_q.mode == bff_pkg::MODE_ADD);
        state_d   = (n_inc == eff_k) ? bff_pkg::ST_RES : bff_pkg::ST_MOD;
      end
      bff_pkg::ST_RDB: state_d = bff_pkg::ST_RES;
      bff_pkg::ST_RES: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = bff_pkg::ST_IDLE;
        end
      end
      default: state_d = bff_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bff_pkg::ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      h1_q        <= bff_pkg::HASH_SEED;
      h2_q        <= bff_pkg::HASH_SEED;
    end else begin
      state_q <= state_d;
      if (state_q == bff_pkg::ST_CLEAR) begin
        clr_q <= clr_q + bff_pkg::ADDR_W'(1);
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == bff_pkg::ST_MUL && mul1_done && mul2_done) begin
        h1_q <= p1;
        h2_q <= p2 + bff_pkg::LCG_INC;
      end else if (state_q == bff_pkg::ST_RMW && n_inc == eff_k) begin
        h1_q <= bff_pkg::HASH_SEED;
        h2_q <= bff_pkg::HASH_SEED;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      item_q        <= q_item_i;
      res_present_q <= 1'b0;
      res_byte_q    <= 8'd0;
      sum_q         <= h1_q;
      shift_q       <= h1_q;
      rem_q         <= '0;
      dig_q         <= '0;
      n_q           <= '0;
      all_q         <= 1'b1;
    end
    unique case (state_q)
      bff_pkg::ST_MUL: begin
        sum_q   <= p1;
        shift_q <= p1;
      end
      bff_pkg::ST_MOD: begin
        rem_q   <= rem_next;
        shift_q <= {shift_q[63-bff_pkg::DIGIT_W:0], {bff_pkg::DIGIT_W{1'b0}}};
        dig_q   <= dig_q + bff_pkg::DIG_CNT_W'(1);
      end
      bff_pkg::ST_RMW: begin
        n_q     <= n_inc;
        sum_q   <= sum_next;
        shift_q <= sum_next;
        rem_q   <= '0;
        dig_q   <= '0;
        res_present_q <= (item_q.mode == bff_pkg::MODE_QUERY) &&
                         all_q && mem_rdata[rem_q[2:0]];
        all_q <= all_q & mem_rdata[rem_q[2:0]];
      end
      bff_pkg::ST_RDB: res_byte_q <= mem_rdata;
      default: ;
    endcase
    if (load_out) begin
      out_kind_q    <= item_q.mode;
      out_present_q <= res_present_q;
      out_byte_q    <= res_byte_q;
    end
  end

  assign clearing_o  = (state_q == bff_pkg::ST_CLEAR);
  assign out_valid_o = out_valid_q;
  assign kind_o      = out_kind_q;
  assign present_o   = out_present_q;
  assign read_byte_o = out_byte_q;

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> state_q == bff_pkg::ST_IDLE)
    else $error("queue popped outside idle");

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bff_pkg::ST_RD |-> rem_q < eff_m)
    else $error("probe position not below bit count");

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bff_pkg::ST_RES && out_valid_q && out_stall_i) |=>
      state_q == bff_pkg::ST_RES)
    else $error("result overwrote a waiting output");

endmodule

// File: tb/bloom_filter_fnv_double_hash_test.sv
module bloom_filter_fnv_double_hash_test;

  // run limits
  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE      = 400;
  localparam int TERM_SLOTS  = 64;
  localparam int TERM_MAXLEN = 8;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  mode_i;
  logic [7:0]  data_byte_i;
  logic        has_byte_i;
  logic        last_i;
  logic [12:0] byte_index_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  kind_o;
  logic        present_o;
  logic [7:0]  read_byte_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [16:0] cfg_value_i;

  bloom_filter_fnv_double_hash u_top (.*);

  // one expected result
  typedef struct {
    logic [1:0] kind;
    logic       present;
    logic [7:0] rbyte;
  } verdict_t;

  bff_pkg::item_t pending_reqs[$];
  verdict_t       expected_verdicts[$];

  // shadow of the filter state
  logic        filter_bits [0:bff_pkg::MAX_BITS-1];
  logic [63:0] fnv_hash;
  logic [63:0] lcg_hash;
  logic [16:0] bits_reg;
  logic [4:0]  probes_reg;

  int unsigned errors;
  int unsigned cycles;
  bit          idle_in_en;
  bit          idle_out_en;

  // known terms, replayed so queries find set bits
  logic [7:0] term_bytes [0:TERM_SLOTS-1][0:TERM_MAXLEN-1];
  int         term_len   [0:TERM_SLOTS-1];
  int         term_total;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[bloom_filter_fnv_double_hash] ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  // gap length: mostly none or short, now and then long
  function automatic int pick_gap(input bit enabled);
    int r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // effective register values after clamping
  function automatic logic [63:0] eff_bits();
    if (bits_reg < bff_pkg::MIN_BITS) return 64'(bff_pkg::MIN_BITS);
    if (bits_reg > bff_pkg::MAX_BITS) return 64'(bff_pkg::MAX_BITS);
    return 64'(bits_reg);
  endfunction

  function automatic int eff_probes();
    if (probes_reg == 0) return 1;
    if (probes_reg > bff_pkg::MAX_HASHES) return bff_pkg::MAX_HASHES;
    return int'(probes_reg);
  endfunction

  // advance the shadow state by one request, queue its result if any
  task automatic predict_request(input bff_pkg::item_t it);
    logic [63:0] sext;
    logic [63:0] pos;
    logic [63:0] modulus;
    verdict_t    v;
    bit          all_set;
    int          k;
    v.kind    = it.mode;
    v.present = 1'b0;
    v.rbyte   = 8'h00;
    if (it.mode == bff_pkg::MODE_ADD || it.mode == bff_pkg::MODE_QUERY) begin
      if (it.has) begin
        // byte taken as a signed char
        sext     = {{56{it.data[7]}}, it.data};
        fnv_hash = (fnv_hash ^ sext) * bff_pkg::FNV_PRIME;
        lcg_hash = (lcg_hash ^ sext) * bff_pkg::LCG_MUL + bff_pkg::LCG_INC;
      end
      if (!it.last) return;
      modulus = eff_bits();
      k       = eff_probes();
      all_set = 1'b1;
      for (int n = 0; n < k; n++) begin
        pos = (fnv_hash + 64'(n) * lcg_hash) % modulus;
        if (it.mode == bff_pkg::MODE_ADD) filter_bits[pos] = 1'b1;
        else if (!filter_bits[pos]) all_set = 1'b0;
      end
      if (it.mode == bff_pkg::MODE_QUERY) v.present = all_set;
      fnv_hash = bff_pkg::HASH_SEED;
      lcg_hash = bff_pkg::HASH_SEED;
    end else if (it.mode == bff_pkg::MODE_LOAD) begin
      for (int b = 0; b < 8; b++) filter_bits[it.idx * 8 + b] = it.data[b];
    end else begin
      for (int b = 0; b < 8; b++) v.rbyte[b] = filter_bits[it.idx * 8 + b];
    end
    expected_verdicts.push_back(v);
  endtask

  // request driver: holds a stalled request, random gaps between requests
  int             in_gap;
  bff_pkg::item_t cur_req;
  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) predict_request(cur_req);
    if (!in_valid_i || !in_stall_o) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        cur_req = pending_reqs.pop_front();
        mode_i       <= cur_req.mode;
        data_byte_i  <= cur_req.data;
        has_byte_i   <= cur_req.has;
        last_i       <= cur_req.last;
        byte_index_i <= cur_req.idx;
        in_valid_i   <= 1'b1;
        in_gap = pick_gap(idle_in_en);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result monitor with random back-pressure
  int out_gap;
  always @(posedge clk_i) begin
    verdict_t v;
    if (out_valid_o && !out_stall_i) begin
      if (expected_verdicts.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        v = expected_verdicts.pop_front();
        if (kind_o !== v.kind)
          report_mismatch($sformatf("kind %0d, want %0d", kind_o, v.kind));
        if (present_o !== v.present)
          report_mismatch($sformatf("present %0b, want %0b", present_o, v.present));
        if (read_byte_o !== v.rbyte)
          report_mismatch($sformatf("read_byte %h, want %h", read_byte_o, v.rbyte));
      end
    end
    if (out_gap > 0) begin
      out_gap--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
      out_gap = pick_gap(idle_out_en);
    end
  end

  task automatic push_req(input bff_pkg::mode_e m, input logic [7:0] d, input bit h,
                          input bit l, input logic [12:0] idx);
    bff_pkg::item_t it;
    it.mode = m;
    it.data = d;
    it.has  = h;
    it.last = l;
    it.idx  = idx;
    pending_reqs.push_back(it);
  endtask

  task automatic push_term(input bff_pkg::mode_e m, input int slot);
    for (int i = 0; i < term_len[slot]; i++)
      push_req(m, term_bytes[slot][i], 1'b1, i == term_len[slot] - 1, 13'($urandom));
  endtask

  function automatic int new_term();
    int slot;
    slot = term_total < TERM_SLOTS ? term_total : $urandom_range(0, TERM_SLOTS - 1);
    if (term_total < TERM_SLOTS) term_total++;
    term_len[slot] = $urandom_range(1, TERM_MAXLEN);
    for (int i = 0; i < TERM_MAXLEN; i++) term_bytes[slot][i] = 8'($urandom);
    return slot;
  endfunction

  // random traffic: mostly whole terms, some broken ones and store access
  task automatic gen_random(input int count);
    int             r;
    int             slot;
    int             start;
    bff_pkg::mode_e m;
    while (pending_reqs.size() < count) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        slot = (term_total > 0 && $urandom_range(0, 1)) ? $urandom_range(0, term_total - 1)
                                                        : new_term();
        m = $urandom_range(0, 2) == 0 ? bff_pkg::MODE_ADD : bff_pkg::MODE_QUERY;
        push_term(m, slot);
      end else if (r < 65) begin
        // broken term: gaps, mode flips and store access in the middle
        start = pending_reqs.size();
        for (int i = 0; i < $urandom_range(1, 5); i++) begin
          case ($urandom_range(0, 3))
            0:       push_req(bff_pkg::MODE_LOAD, 8'($urandom), 1'b1, 1'b0, 13'($urandom));
            1:       push_req(bff_pkg::MODE_READ, 8'($urandom), 1'b1, 1'b1, 13'($urandom));
            default: push_req(bff_pkg::mode_e'($urandom_range(0, 1)), 8'($urandom),
                              1'($urandom), 1'b0, 13'($urandom));
          endcase
        end
        push_req(bff_pkg::mode_e'($urandom_range(0, 1)), 8'($urandom), 1'($urandom), 1'b1,
                 13'($urandom));
      end else if (r < 72) begin
        push_req(bff_pkg::mode_e'($urandom_range(0, 1)), 8'($urandom), 1'b0, 1'b1,
                 13'($urandom));
      end else if (r < 84) begin
        push_req(bff_pkg::MODE_LOAD, 8'($urandom), 1'($urandom), 1'($urandom),
                 13'($urandom));
      end else begin
        push_req(bff_pkg::MODE_READ, 8'($urandom), 1'($urandom), 1'($urandom),
                 13'($urandom));
      end
    end
  endtask

  task automatic write_reg(input bff_pkg::cfg_idx_e idx, input logic [16:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_value_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == bff_pkg::CFG_BIT_COUNT) bits_reg = value;
    else probes_reg = value[4:0];
  endtask

  // let everything drain, then wait out a possible term end with no result
  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid_i || expected_verdicts.size() > 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // register settings per phase, extremes and out-of-range values included
  logic [16:0] phase_bits  [0:6] = '{17'd65536, 17'd64, 17'd0, 17'd131071,
                                     17'd1000, 17'd63, 17'd4099};
  logic [16:0] phase_probes[0:6] = '{17'd7, 17'd1, 17'd0, 17'd31,
                                     17'd16, 17'd17, 17'd5};

  initial begin
    int slot;
    errors       = 0;
    cycles       = 0;
    term_total   = 0;
    in_gap       = 0;
    out_gap      = 0;
    idle_in_en   = 1'b1;
    idle_out_en  = 1'b1;
    in_valid_i   = 1'b0;
    out_stall_i  = 1'b0;
    mode_i       = '0;
    data_byte_i  = '0;
    has_byte_i   = 1'b0;
    last_i       = 1'b0;
    byte_index_i = '0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = '0;
    cfg_value_i  = '0;
    for (int i = 0; i < bff_pkg::MAX_BITS; i++) filter_bits[i] = 1'b0;
    fnv_hash   = bff_pkg::HASH_SEED;
    lcg_hash   = bff_pkg::HASH_SEED;
    bits_reg   = 17'd65536;
    probes_reg = 5'd7;
    rst_ni     = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty terms, query before add, extreme bytes, broken terms
    push_req(bff_pkg::MODE_QUERY, 8'h00, 1'b0, 1'b1, 13'd0);
    push_req(bff_pkg::MODE_ADD,   8'hff, 1'b0, 1'b1, 13'h1fff);
    push_req(bff_pkg::MODE_QUERY, 8'h00, 1'b0, 1'b1, 13'd0);
    slot = new_term();
    term_len[slot] = 4;
    term_bytes[slot][0] = 8'h00;
    term_bytes[slot][1] = 8'hff;
    term_bytes[slot][2] = 8'h80;
    term_bytes[slot][3] = 8'h7f;
    push_term(bff_pkg::MODE_QUERY, slot);
    push_term(bff_pkg::MODE_ADD, slot);
    push_term(bff_pkg::MODE_QUERY, slot);
    // mode flip inside a term, the last byte decides
    push_req(bff_pkg::MODE_ADD,   8'h41, 1'b1, 1'b0, 13'd0);
    push_req(bff_pkg::MODE_QUERY, 8'h42, 1'b1, 1'b1, 13'd0);
    // store access and a missing byte inside a term
    push_req(bff_pkg::MODE_ADD,   8'h41, 1'b1, 1'b0, 13'd0);
    push_req(bff_pkg::MODE_LOAD,  8'hff, 1'b1, 1'b0, 13'd0);
    push_req(bff_pkg::MODE_READ,  8'h00, 1'b0, 1'b1, 13'd0);
    push_req(bff_pkg::MODE_ADD,   8'h99, 1'b0, 1'b0, 13'd0);
    push_req(bff_pkg::MODE_QUERY, 8'h42, 1'b1, 1'b1, 13'd0);
    push_req(bff_pkg::MODE_LOAD,  8'h5a, 1'b0, 1'b1, 13'h1fff);
    push_req(bff_pkg::MODE_READ,  8'h00, 1'b1, 1'b0, 13'h1fff);
    push_req(bff_pkg::MODE_LOAD,  8'h00, 1'b1, 1'b1, 13'd0);
    push_req(bff_pkg::MODE_READ,  8'h00, 1'b1, 1'b1, 13'd0);
    push_req(bff_pkg::MODE_READ,  8'h00, 1'b1, 1'b1, 13'd4096);
    drain();

    for (int p = 0; p < 7; p++) begin
      write_reg(bff_pkg::CFG_BIT_COUNT, phase_bits[p]);
      write_reg(bff_pkg::CFG_HASH_COUNT, phase_probes[p]);
      // some phases run without idling on either side
      idle_in_en  = (p % 3) != 1;
      idle_out_en = (p % 3) != 2;
      gen_random(150);
      drain();
    end

    if (errors == 0) begin
      $display("[bloom_filter_fnv_double_hash] OK");
    end else begin
      $display("[bloom_filter_fnv_double_hash] ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/bff_pkg.sv
hdl/bff_ram.sv
hdl/bff_queue.sv
hdl/bff_mul.sv
hdl/bff_core.sv
hdl/bloom_filter_fnv_double_hash.sv
tb/bloom_filter_fnv_double_hash_test.sv
